// ===== src/b64sd_pkg.sv =====
// b64sd_pkg: types, constants and character classification for the base64 stream decoder
// no dependencies; imported by every module of the decoder
`default_nettype none
package b64sd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int BYTE_COUNT_W = 16;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UZ  = 8'h5A;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LZ  = 8'h7A;
    localparam logic [7:0] CHAR_D0  = 8'h30;
    localparam logic [7:0] CHAR_D9  = 8'h39;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef enum logic [1:0] {
        KIND_SEXTET,
        KIND_SKIP,
        KIND_PAD,
        KIND_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] val;
    } t_class;

    // one queued transaction group: up to three bytes plus end-of-text info
    typedef struct packed {
        logic [2:0][7:0]           bytes;
        logic [1:0]                nb;
        logic                      eot;
        logic [BYTE_COUNT_W-1:0]   count;
    } t_job;

    function automatic t_class classify(input logic [7:0] ch);
        t_class c;
        c.kind = KIND_OTHER;
        c.val  = 6'd0;
        case (ch) inside
            [CHAR_UA:CHAR_UZ]: begin
                c.kind = KIND_SEXTET;
                c.val  = 6'(ch - CHAR_UA);
            end
            [CHAR_LA:CHAR_LZ]: begin
                c.kind = KIND_SEXTET;
                c.val  = SEXTET_LOWER + 6'(ch - CHAR_LA);
            end
            [CHAR_D0:CHAR_D9]: begin
                c.kind = KIND_SEXTET;
                c.val  = SEXTET_DIGIT + 6'(ch - CHAR_D0);
            end
            CHAR_PLUS: begin
                c.kind = KIND_SEXTET;
                c.val  = SEXTET_PLUS;
            end
            CHAR_SLASH: begin
                c.kind = KIND_SEXTET;
                c.val  = SEXTET_SLASH;
            end
            CHAR_CR, CHAR_LF: begin
                c.kind = KIND_SKIP;
            end
            CHAR_EQ: begin
                c.kind = KIND_PAD;
            end
            default: begin
                c.kind = KIND_OTHER;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/base64_stream_decoder_core.sv =====
// base64_stream_decoder_core: top level of the streaming base64 decoder
// depends on b64sd_pkg, b64sd_front, b64sd_queue and b64sd_back
//
// Takes one text character per cycle while full is low and gives one result per cycle while
// pop is held. The front end classifies each character and updates the group state in the
// cycle it is accepted, so a new character can enter every cycle; each character turns into
// at most one job (up to three bytes, or an end-of-text marker) in a four-entry job queue.
// The back end hands out one result per pop, so a full group of four characters needs three
// results and the stream sustains one character per cycle. full rises only when the job queue
// fills while results are not popped; each result is registered in the queue and back end.
`default_nettype none
module base64_stream_decoder_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_char,
    input  wire logic        i_end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_data_byte,
    output logic             o_byte_valid,
    output logic             o_run_last,
    output logic             o_text_done,
    output logic [15:0]      o_byte_count
);
    import b64sd_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;
    logic accept;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    b64sd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .o_job         (front_job),
        .o_job_push    (front_push)
    );

    b64sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    b64sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (queue_job),
        .i_job_empty  (queue_empty),
        .o_job_pop    (queue_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_text_done  (o_text_done),
        .o_byte_count (o_byte_count)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_text_done) |-> o_run_last)
        else $error("text done on a result that is not last");

    a_invalid_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_text_done && o_data_byte == 8'd0))
        else $error("empty result outside end of text");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> !queue_full)
        else $error("job lost at full queue");

endmodule
`default_nettype wire

// ===== src/b64sd_front.sv =====
// b64sd_front: accepts characters, classifies them and keeps the group state
// depends on b64sd_pkg; produces jobs for b64sd_queue
`default_nettype none
module b64sd_front #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_text_char,
    input  wire logic            i_end_of_text,
    output b64sd_pkg::t_job      o_job,
    output logic                 o_job_push
);
    import b64sd_pkg::*;

    localparam int CNT_W = (COUNT_BITS < BYTE_COUNT_W) ? COUNT_BITS : BYTE_COUNT_W;

    logic [23:0]      r_acc,   n_acc;
    logic [1:0]       r_fill,  n_fill;
    logic [5:0]       r_prev,  n_prev;
    logic             r_pad,   n_pad;
    logic [CNT_W-1:0] r_count, n_count;

    t_class           cls;
    logic [5:0]       sextet;
    logic [23:0]      acc_shift;
    logic [2:0][7:0]  bytes;
    logic [1:0]       nb;
    logic [CNT_W+1:0] sum;

    always_comb begin
        cls       = classify(i_text_char);
        sextet    = (cls.kind == KIND_OTHER) ? r_prev : cls.val;
        acc_shift = {r_acc[17:0], sextet};
        n_acc     = r_acc;
        n_fill    = r_fill;
        n_prev    = r_prev;
        n_pad     = r_pad;
        bytes     = '0;
        nb        = 2'd0;
        if (!r_pad) begin
            case (cls.kind)
                KIND_SEXTET, KIND_OTHER: begin
                    n_prev = sextet;
                    if (r_fill == 2'd3) begin
                        bytes[0] = acc_shift[23:16];
                        bytes[1] = acc_shift[15:8];
                        bytes[2] = acc_shift[7:0];
                        nb       = 2'd3;
                        n_acc    = '0;
                        n_fill   = 2'd0;
                    end else begin
                        n_acc  = acc_shift;
                        n_fill = r_fill + 2'd1;
                    end
                end
                KIND_PAD: begin
                    if (r_fill == 2'd3) begin
                        bytes[0] = r_acc[17:10];
                        bytes[1] = r_acc[9:2];
                        nb       = 2'd2;
                    end else if (r_fill == 2'd2) begin
                        bytes[0] = r_acc[11:4];
                        nb       = 2'd1;
                    end
                    n_pad = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // saturating byte count
        sum = {2'b00, r_count} + (CNT_W + 2)'(nb);
        if (sum[CNT_W+1:CNT_W] != 2'b00) begin
            n_count = '1;
        end else begin
            n_count = sum[CNT_W-1:0];
        end

        o_job.bytes = bytes;
        o_job.nb    = nb;
        o_job.eot   = i_end_of_text;
        o_job.count = BYTE_COUNT_W'(n_count);
        o_job_push  = i_accept && ((nb != 2'd0) || i_end_of_text);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_fill  <= '0;
            r_prev  <= '0;
            r_pad   <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            if (i_end_of_text) begin
                r_acc   <= '0;
                r_fill  <= '0;
                r_prev  <= '0;
                r_pad   <= 1'b0;
                r_count <= '0;
            end else begin
                r_acc   <= n_acc;
                r_fill  <= n_fill;
                r_prev  <= n_prev;
                r_pad   <= n_pad;
                r_count <= n_count;
            end
        end
    end

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text) |=> (r_fill == 2'd0 && !r_pad && r_count == '0))
        else $error("state not cleared after end of text");

    a_full_group_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job.nb == 2'd3) |-> (r_fill == 2'd3 && !r_pad))
        else $error("three bytes without a full group");

    a_pad_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad && !(i_accept && i_end_of_text)) |=> (r_pad && $stable(r_fill)))
        else $error("state changed after pad");

endmodule
`default_nettype wire

// ===== src/b64sd_queue.sv =====
// b64sd_queue: small job queue between the front and back ends
// depends on b64sd_pkg
`default_nettype none
module b64sd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  b64sd_pkg::t_job      i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output b64sd_pkg::t_job      o_job,
    output logic                 o_empty
);
    import b64sd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("pointers disagree with empty queue");

endmodule
`default_nettype wire

// ===== src/b64sd_back.sv =====
// b64sd_back: unpacks queued jobs into one result per transaction
// depends on b64sd_pkg; fed by b64sd_queue
`default_nettype none
module b64sd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  b64sd_pkg::t_job      i_job,
    input  wire logic            i_job_empty,
    output logic                 o_job_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_data_byte,
    output logic                 o_byte_valid,
    output logic                 o_run_last,
    output logic                 o_text_done,
    output logic [15:0]          o_byte_count
);
    import b64sd_pkg::*;

    t_job       r_job;
    logic       r_valid;
    logic [1:0] r_idx;
    logic [1:0] last_idx;
    logic       is_last;
    logic       take;
    logic       load;

    always_comb begin
        last_idx     = (r_job.nb == 2'd0) ? 2'd0 : r_job.nb - 2'd1;
        is_last      = (r_idx == last_idx);
        take         = i_pop && r_valid;
        load         = (!r_valid || (take && is_last)) && !i_job_empty;
        o_job_pop    = load;
        o_empty      = !r_valid;
        o_byte_valid = (r_job.nb != 2'd0);
        o_data_byte  = o_byte_valid ? r_job.bytes[r_idx] : 8'd0;
        o_run_last   = is_last;
        o_text_done  = r_job.eot && is_last;
        o_byte_count = o_text_done ? r_job.count : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= last_idx))
        else $error("result index past job end");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_idx)))
        else $error("result moved without pop");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (!r_valid || (take && is_last)))
        else $error("job loaded over a pending result");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for base64_stream_decoder_core, one character per transaction
// depends on b64sd_pkg and base64_stream_decoder_core; predicts each decoded byte in-bench
module tb_top;
    import b64sd_pkg::*;

    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          RX_HOLD_CYCLES = 80;
    localparam int          RANDOM_CHARS   = 120;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam string       B64_ALPHABET   =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        last;
        logic        done;
        logic [15:0] count;
    } t_byte_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_text_char = 8'd0;
    logic        i_end_of_text = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_byte_valid;
    logic        o_run_last;
    logic        o_text_done;
    logic [15:0] o_byte_count;

    // decoder state as predicted by the bench
    logic [23:0] dec_acc = '0;
    logic [1:0]  dec_fill = '0;
    logic [5:0]  dec_prev = '0;
    logic        dec_pad_seen = 1'b0;
    logic [15:0] dec_count = '0;

    t_byte_result pending_bytes[$];
    t_byte_result want;

    int   idle_pct = 14;
    logic rx_hold = 1'b0;
    int   n_errors = 0;
    int   n_chars = 0;
    int   n_texts = 0;
    int   n_checked = 0;
    int   n_full_cycles = 0;
    int   cycle_count = 0;

    base64_stream_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_data_byte   (o_data_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_text_done   (o_text_done),
        .o_byte_count  (o_byte_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic predict_char(input logic [7:0] ch, input logic eot);
        t_kind        kind;
        logic [5:0]   v;
        logic [7:0]   b [3];
        int           nb;
        int           n;
        t_byte_result r;
        nb = 0;
        v = 6'd0;
        kind = KIND_OTHER;
        b[0] = 8'd0;
        b[1] = 8'd0;
        b[2] = 8'd0;
        if (!dec_pad_seen) begin
            if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
                kind = KIND_SEXTET;
                v = 6'(ch - CHAR_UA);
            end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
                kind = KIND_SEXTET;
                v = SEXTET_LOWER + 6'(ch - CHAR_LA);
            end else if (ch >= CHAR_D0 && ch <= CHAR_D9) begin
                kind = KIND_SEXTET;
                v = SEXTET_DIGIT + 6'(ch - CHAR_D0);
            end else if (ch == CHAR_PLUS) begin
                kind = KIND_SEXTET;
                v = SEXTET_PLUS;
            end else if (ch == CHAR_SLASH) begin
                kind = KIND_SEXTET;
                v = SEXTET_SLASH;
            end else if (ch == CHAR_CR || ch == CHAR_LF) begin
                kind = KIND_SKIP;
            end else if (ch == CHAR_EQ) begin
                kind = KIND_PAD;
            end else begin
                // unknown characters repeat the last sextet
                kind = KIND_SEXTET;
                v = dec_prev;
            end
            case (kind)
                KIND_SEXTET: begin
                    dec_prev = v;
                    dec_acc = {dec_acc[17:0], v};
                    if (dec_fill == 2'd3) begin
                        b[0] = dec_acc[23:16];
                        b[1] = dec_acc[15:8];
                        b[2] = dec_acc[7:0];
                        nb = 3;
                        dec_acc = '0;
                        dec_fill = '0;
                    end else begin
                        dec_fill = dec_fill + 2'd1;
                    end
                end
                KIND_PAD: begin
                    if (dec_fill == 2'd3) begin
                        b[0] = dec_acc[17:10];
                        b[1] = dec_acc[9:2];
                        nb = 2;
                    end else if (dec_fill == 2'd2) begin
                        b[0] = dec_acc[11:4];
                        nb = 1;
                    end
                    dec_pad_seen = 1'b1;
                end
                default: begin
                end
            endcase
        end
        for (int k = 0; k < nb; k++) begin
            if (dec_count != COUNT_MAX) dec_count = dec_count + 16'd1;
        end
        n = (eot && nb == 0) ? 1 : nb;
        for (int k = 0; k < n; k++) begin
            r.data  = (k < nb) ? b[k] : 8'd0;
            r.valid = (k < nb);
            r.last  = (k == n - 1);
            r.done  = eot && (k == n - 1);
            r.count = r.done ? dec_count : 16'd0;
            pending_bytes.push_back(r);
        end
        if (eot) begin
            dec_acc = '0;
            dec_fill = '0;
            dec_prev = '0;
            dec_pad_seen = 1'b0;
            dec_count = '0;
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic eot);
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_text_char <= ch;
        i_end_of_text <= eot;
        predict_char(ch, eot);
        @(posedge i_clk);
        while (full) begin
            n_full_cycles++;
            @(posedge i_clk);
        end
        n_chars++;
        if (eot) n_texts++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_random_text();
        logic [7:0] chars[$];
        int         flavor;
        int         groups;
        int         tail;
        int         len;
        int         pick;
        flavor = $urandom_range(0, 9);
        if (flavor < 7) begin
            groups = $urandom_range(1, 6);
            for (int g = 0; g < groups; g++) begin
                for (int j = 0; j < 4; j++) begin
                    if ($urandom_range(0, 9) == 0)
                        chars.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                    chars.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
                end
            end
            tail = $urandom_range(0, 2);
            if (tail == 1) begin
                chars.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
                chars.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
                chars.push_back(CHAR_EQ);
                chars.push_back(CHAR_EQ);
            end else if (tail == 2) begin
                for (int j = 0; j < 3; j++) chars.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
                chars.push_back(CHAR_EQ);
            end
        end else begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
                pick = $urandom_range(0, 9);
                if (flavor == 9 || pick > 6)
                    chars.push_back(8'($urandom_range(0, 255)));
                else if (pick < 5)
                    chars.push_back(B64_ALPHABET[$urandom_range(0, 63)]);
                else if (pick == 5)
                    chars.push_back(CHAR_EQ);
                else
                    chars.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
        end
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic test_alphabet();
        send_text("AZaz09+/");
    endtask

    task automatic test_other_chars();
        send_char(8'h00, 1'b0);
        send_char(CHAR_CR, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("b", 1'b0);
        send_char(CHAR_LF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char("Z", 1'b0);
        send_char(CHAR_EQ, 1'b0);
        send_char(8'h7F, 1'b1);
    endtask

    task automatic test_padding();
        send_text("=");
        send_text("QUJ=");
        send_text("QU=x");
        send_text("Z");
    endtask

    task automatic test_streaming();
        idle_pct = 0;
        for (int t = 0; t < 12; t++) send_random_text();
        idle_pct = 14;
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int t = 0; t < 10; t++) send_text("QUJDRA==");
    endtask

    task automatic test_random_texts();
        int target;
        target = n_chars + RANDOM_CHARS;
        while (n_chars < target) send_random_text();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_bytes.size() == 0) begin
                    n_errors++;
                    $error("unexpected result transaction, data_byte %0h", o_data_byte);
                end else begin
                    want = pending_bytes.pop_front();
                    n_checked++;
                    if (o_data_byte !== want.data) begin
                        n_errors++;
                        $error("data_byte expected %0h actual %0h", want.data, o_data_byte);
                    end
                    if (o_byte_valid !== want.valid) begin
                        n_errors++;
                        $error("byte_valid expected %0b actual %0b", want.valid, o_byte_valid);
                    end
                    if (o_run_last !== want.last) begin
                        n_errors++;
                        $error("run_last expected %0b actual %0b", want.last, o_run_last);
                    end
                    if (o_text_done !== want.done) begin
                        n_errors++;
                        $error("text_done expected %0b actual %0b", want.done, o_text_done);
                    end
                    if (o_byte_count !== want.count) begin
                        n_errors++;
                        $error("byte_count expected %0d actual %0d", want.count, o_byte_count);
                    end
                end
            end
            pop <= !rx_hold && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alphabet();
        test_other_chars();
        test_padding();
        test_streaming();
        test_backpressure();
        test_random_texts();
        push <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d characters in %0d texts, checked %0d results",
                 n_chars, n_texts, n_checked);
        $display("input stalled %0d cycles; padding, line breaks and unknown characters hit",
                 n_full_cycles);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
